FILE: design/pfde_pkg.sv
`timescale 1ns / 1ps
package pfde_pkg;

	// Field widths of the command and data beats
	localparam int CMD_W   = 3;
	localparam int COORD_W = 8;
	localparam int COFF_W  = 4;
	localparam int BITS_W  = 8;
	localparam int CHUNK_W = 5;
	localparam int DATA_W  = 8;

	// Internal widths: rows and columns may run past 255 before clipping
	localparam int ROW_W   = 9;
	localparam int COL_W   = 9;
	localparam int PAGE_W  = 5;
	// Wide enough for any store address or chunk start across the parameter range
	localparam int CADDR_W = 13;

	// Longest chunk readout in bytes
	localparam int MAX_READ = 32;

	// Defaults for the top-level parameters
	localparam int DEF_SCREEN_WIDTH  = 128;
	localparam int DEF_SCREEN_HEIGHT = 64;
	localparam int DEF_CHUNK_BYTES   = 32;
	localparam int DEF_QUEUE_DEPTH   = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 3'd0,
		CMD_PIXEL = 3'd1,
		CMD_RECT  = 3'd2,
		CMD_GLYPH = 3'd3,
		CMD_READ  = 3'd4
	} cmd_code_t;

	typedef enum logic [1:0] {
		OP_FILL = 2'd0,
		OP_DRAW = 2'd1,
		OP_READ = 2'd2
	} op_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_FILL    = 3'd1,
		ST_DRAW_RD = 3'd2,
		ST_DRAW_WR = 3'd3,
		ST_READ_RD = 3'd4,
		ST_READ_OUT = 3'd5
	} back_state_t;

	// Decoded operation handed from the front end to the back end
	typedef struct packed {
		op_kind_t           kind;
		logic               light;
		logic               glyph;
		logic [15:0]        pattern;
		logic [COL_W-1:0]   col_lo;
		logic [COL_W-1:0]   col_hi;
		logic [ROW_W-1:0]   row_lo;
		logic [ROW_W-1:0]   row_hi;
		logic [PAGE_W-1:0]  page_lo;
		logic [PAGE_W-1:0]  page_hi;
		logic [CADDR_W-1:0] base;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: design/pfde_req_if.sv
`timescale 1ns / 1ps
interface pfde_req_if;
	logic                          valid;
	logic                          ready;
	logic [pfde_pkg::CMD_W-1:0]    cmd;
	logic [pfde_pkg::COORD_W-1:0]  x;
	logic [pfde_pkg::COORD_W-1:0]  y;
	logic [pfde_pkg::COFF_W-1:0]   col_offset;
	logic [pfde_pkg::COORD_W-1:0]  width;
	logic [pfde_pkg::COORD_W-1:0]  height;
	logic                          on;
	logic [pfde_pkg::BITS_W-1:0]   top_bits;
	logic [pfde_pkg::BITS_W-1:0]   bottom_bits;
	logic                          msb_first;
	logic [pfde_pkg::CHUNK_W-1:0]  chunk;

	modport source (
		output valid, cmd, x, y, col_offset, width, height, on,
		       top_bits, bottom_bits, msb_first, chunk,
		input  ready
	);
	modport sink (
		input  valid, cmd, x, y, col_offset, width, height, on,
		       top_bits, bottom_bits, msb_first, chunk,
		output ready
	);
endinterface

FILE: design/pfde_rsp_if.sv
`timescale 1ns / 1ps
interface pfde_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [pfde_pkg::DATA_W-1:0] data_byte;
	logic                        last;

	modport source (output valid, data_byte, last, input ready);
	modport sink (input valid, data_byte, last, output ready);
endinterface

FILE: design/pfde_ram.sv
`timescale 1ns / 1ps
module pfde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/pfde_queue.sv
`timescale 1ns / 1ps
module pfde_queue #(
	parameter int DEPTH = pfde_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pfde_pkg::op_t         din,
	input  logic                  pop,
	output pfde_pkg::op_t         dout,
	output pfde_pkg::q_status_t   status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	pfde_pkg::op_t    entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign dout         = entries_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_FULL);
	assign status.empty = (count_q == '0);

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("queue popped while empty");

endmodule

FILE: design/pfde_front.sv
`timescale 1ns / 1ps
module pfde_front #(
	parameter int SCREEN_WIDTH  = pfde_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = pfde_pkg::DEF_SCREEN_HEIGHT,
	parameter int CHUNK_BYTES   = pfde_pkg::DEF_CHUNK_BYTES
) (
	input  logic                init_done,
	input  pfde_pkg::q_status_t q_status,
	pfde_req_if.sink            req,
	output logic                push,
	output pfde_pkg::op_t       op
);

	localparam logic [pfde_pkg::COL_W-1:0] COL_LIMIT = pfde_pkg::COL_W'(SCREEN_WIDTH);
	localparam logic [pfde_pkg::ROW_W-1:0] ROW_LIMIT = pfde_pkg::ROW_W'(SCREEN_HEIGHT);

	logic keep;

	// take a beat once the store is initialised and the queue has room
	assign req.ready = init_done && !q_status.full;
	assign push      = req.valid && req.ready && keep;

	// classify the command and clip its area to the screen
	always_comb begin
		logic [pfde_pkg::COL_W-1:0]   x9;
		logic [pfde_pkg::ROW_W-1:0]   y9;
		logic [pfde_pkg::COL_W-1:0]   col_lo;
		logic [pfde_pkg::COL_W-1:0]   col_hi_raw;
		logic [pfde_pkg::COL_W-1:0]   col_hi;
		logic [pfde_pkg::ROW_W-1:0]   row_hi_raw;
		logic [pfde_pkg::ROW_W-1:0]   row_hi;
		logic [pfde_pkg::ROW_W-1:0]   row_last;
		logic [pfde_pkg::CADDR_W-1:0] page_base;
		logic [15:0]                  glyph;
		logic                         draw;
		logic                         is_glyph;

		x9         = {1'b0, req.x};
		y9         = {1'b0, req.y};
		col_lo     = x9;
		col_hi_raw = x9 + 9'd1;
		row_hi_raw = y9 + 9'd1;
		draw       = 1'b0;
		is_glyph   = 1'b0;
		keep       = 1'b0;
		op         = '0;

		// glyph column in row order from the top edge
		for (int i = 0; i < 8; i++) begin
			glyph[i]     = req.msb_first ? req.top_bits[7 - i]    : req.top_bits[i];
			glyph[8 + i] = req.msb_first ? req.bottom_bits[7 - i] : req.bottom_bits[i];
		end

		case (req.cmd)
			pfde_pkg::CMD_CLEAR: begin
				op.kind  = pfde_pkg::OP_FILL;
				op.light = req.on;
				keep     = 1'b1;
			end
			pfde_pkg::CMD_PIXEL: begin
				draw = 1'b1;
			end
			pfde_pkg::CMD_RECT: begin
				// end column and row wrap at 256
				col_hi_raw = {1'b0, 8'(req.x + req.width)};
				row_hi_raw = {1'b0, 8'(req.y + req.height)};
				draw       = 1'b1;
			end
			pfde_pkg::CMD_GLYPH: begin
				col_lo     = x9 + pfde_pkg::COL_W'(req.col_offset);
				col_hi_raw = col_lo + 9'd1;
				row_hi_raw = y9 + 9'd16;
				draw       = 1'b1;
				is_glyph   = 1'b1;
			end
			pfde_pkg::CMD_READ: begin
				op.kind = pfde_pkg::OP_READ;
				op.base = pfde_pkg::CADDR_W'(req.chunk) * pfde_pkg::CADDR_W'(CHUNK_BYTES);
				keep    = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase

		col_hi    = (col_hi_raw > COL_LIMIT) ? COL_LIMIT : col_hi_raw;
		row_hi    = (row_hi_raw > ROW_LIMIT) ? ROW_LIMIT : row_hi_raw;
		row_last  = row_hi - 9'd1;
		page_base = pfde_pkg::CADDR_W'(y9[7:3]) * pfde_pkg::CADDR_W'(SCREEN_WIDTH);

		if (draw) begin
			op.kind    = pfde_pkg::OP_DRAW;
			op.light   = is_glyph ? 1'b1 : req.on;
			op.glyph   = is_glyph;
			op.pattern = glyph;
			op.col_lo  = col_lo;
			op.col_hi  = col_hi;
			op.row_lo  = y9;
			op.row_hi  = row_hi;
			op.page_lo = y9[7:3];
			op.page_hi = row_last[7:3];
			op.base    = page_base;
			// empty after clipping: nothing to queue
			keep       = (col_lo < col_hi) && (y9 < row_hi);
		end
	end

endmodule

FILE: design/pfde_back.sv
`timescale 1ns / 1ps
module pfde_back #(
	parameter int SCREEN_WIDTH  = pfde_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = pfde_pkg::DEF_SCREEN_HEIGHT,
	parameter int CHUNK_BYTES   = pfde_pkg::DEF_CHUNK_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pfde_pkg::op_t       q_head,
	input  pfde_pkg::q_status_t q_status,
	output logic                pop,
	output logic                init_done,
	pfde_rsp_if.source          rsp
);

	localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int SUM_W       = ((ADDR_W > pfde_pkg::COL_W) ? ADDR_W : pfde_pkg::COL_W) + 1;
	localparam int READ_BYTES  = (CHUNK_BYTES < pfde_pkg::MAX_READ) ? CHUNK_BYTES
	                                                                 : pfde_pkg::MAX_READ;
	localparam int KW          = (READ_BYTES > 1) ? $clog2(READ_BYTES) : 1;
	localparam logic [ADDR_W-1:0] FILL_LAST = ADDR_W'(STORE_BYTES - 1);
	localparam logic [KW-1:0]     K_LAST    = KW'(READ_BYTES - 1);
	localparam logic [pfde_pkg::CADDR_W-1:0] STORE_END = pfde_pkg::CADDR_W'(STORE_BYTES);

	pfde_pkg::back_state_t state_q;
	pfde_pkg::back_state_t state_n;
	pfde_pkg::op_t         op_q;

	logic                        init_done_q;
	logic                        fill_val_q;
	logic [ADDR_W-1:0]           fill_addr_q;
	logic [pfde_pkg::PAGE_W-1:0] page_q;
	logic [pfde_pkg::COL_W-1:0]  col_q;
	logic [ADDR_W-1:0]           base_q;
	logic [KW-1:0]               k_q;
	logic                        rd_inrange_q;
	logic                        out_valid_q;
	logic [pfde_pkg::DATA_W-1:0] out_data_q;
	logic                        out_last_q;

	logic                        ram_we;
	logic [ADDR_W-1:0]           ram_waddr;
	logic [pfde_pkg::DATA_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [ADDR_W-1:0]           ram_raddr;
	logic [pfde_pkg::DATA_W-1:0] ram_rdata;

	logic                        fill_end;
	logic                        col_end;
	logic                        page_end;
	logic                        k_end;
	logic                        out_free;
	logic                        out_load;
	logic [SUM_W-1:0]            draw_sum;
	logic [SUM_W-1:0]            base_sum;
	logic [pfde_pkg::CADDR_W-1:0] rd_sum;
	logic                        rd_in_range;
	logic [7:0]                  mask;

	pfde_ram #(
		.WIDTH (pfde_pkg::DATA_W),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// address arithmetic and loop ends
	assign fill_end    = (fill_addr_q == FILL_LAST);
	assign col_end     = (col_q == op_q.col_hi - 9'd1);
	assign page_end    = (page_q == op_q.page_hi);
	assign k_end       = (k_q == K_LAST);
	assign draw_sum    = SUM_W'(base_q) + SUM_W'(col_q);
	assign base_sum    = SUM_W'(base_q) + SUM_W'(SCREEN_WIDTH);
	assign rd_sum      = op_q.base + pfde_pkg::CADDR_W'(k_q);
	assign rd_in_range = (rd_sum < STORE_END);
	assign out_free    = !out_valid_q || rsp.ready;

	// row mask of the current page: rows inside the area, glyph bits where set
	always_comb begin
		logic [pfde_pkg::ROW_W-1:0] row_v;
		logic [pfde_pkg::ROW_W-1:0] diff_v;
		for (int r = 0; r < 8; r++) begin
			row_v   = {1'b0, page_q, 3'(r)};
			diff_v  = row_v - op_q.row_lo;
			mask[r] = (row_v >= op_q.row_lo) && (row_v < op_q.row_hi)
			          && (!op_q.glyph || ((diff_v < 9'd16) && op_q.pattern[diff_v[3:0]]));
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			pfde_pkg::ST_IDLE: begin
				if (!q_status.empty) begin
					case (q_head.kind)
						pfde_pkg::OP_FILL: state_n = pfde_pkg::ST_FILL;
						pfde_pkg::OP_DRAW: state_n = pfde_pkg::ST_DRAW_RD;
						pfde_pkg::OP_READ: state_n = pfde_pkg::ST_READ_RD;
						default:           state_n = pfde_pkg::ST_IDLE;
					endcase
				end
			end
			pfde_pkg::ST_FILL: begin
				if (fill_end) begin
					state_n = pfde_pkg::ST_IDLE;
				end
			end
			pfde_pkg::ST_DRAW_RD: begin
				state_n = pfde_pkg::ST_DRAW_WR;
			end
			pfde_pkg::ST_DRAW_WR: begin
				if (col_end && page_end) begin
					state_n = pfde_pkg::ST_IDLE;
				end else begin
					state_n = pfde_pkg::ST_DRAW_RD;
				end
			end
			pfde_pkg::ST_READ_RD: begin
				state_n = pfde_pkg::ST_READ_OUT;
			end
			pfde_pkg::ST_READ_OUT: begin
				if (out_free) begin
					state_n = k_end ? pfde_pkg::ST_IDLE : pfde_pkg::ST_READ_RD;
				end
			end
			default: begin
				state_n = pfde_pkg::ST_IDLE;
			end
		endcase
	end

	// store accesses and hand-offs per state
	always_comb begin
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = draw_sum[ADDR_W-1:0];
		ram_wdata = op_q.light ? (ram_rdata | mask) : (ram_rdata & ~mask);
		ram_re    = 1'b0;
		ram_raddr = draw_sum[ADDR_W-1:0];
		out_load  = 1'b0;
		unique case (state_q)
			pfde_pkg::ST_IDLE: begin
				pop = !q_status.empty;
			end
			pfde_pkg::ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = fill_addr_q;
				ram_wdata = {pfde_pkg::DATA_W{fill_val_q}};
			end
			pfde_pkg::ST_DRAW_RD: begin
				ram_re = 1'b1;
			end
			pfde_pkg::ST_DRAW_WR: begin
				ram_we = 1'b1;
			end
			pfde_pkg::ST_READ_RD: begin
				ram_re    = rd_in_range;
				ram_raddr = rd_sum[ADDR_W-1:0];
			end
			pfde_pkg::ST_READ_OUT: begin
				out_load = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfde_pkg::ST_FILL;
			init_done_q <= 1'b0;
			fill_val_q  <= 1'b0;
			fill_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (pop) begin
				fill_val_q  <= q_head.light;
				fill_addr_q <= '0;
			end else if (state_q == pfde_pkg::ST_FILL) begin
				fill_addr_q <= fill_addr_q + 1'b1;
			end
			if (state_q == pfde_pkg::ST_FILL && fill_end) begin
				init_done_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operation, loop counters and output beat
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q   <= q_head;
			page_q <= q_head.page_lo;
			col_q  <= q_head.col_lo;
			base_q <= q_head.base[ADDR_W-1:0];
			k_q    <= '0;
		end else if (state_q == pfde_pkg::ST_DRAW_WR) begin
			if (col_end) begin
				col_q  <= op_q.col_lo;
				page_q <= page_q + 1'b1;
				base_q <= base_sum[ADDR_W-1:0];
			end else begin
				col_q <= col_q + 1'b1;
			end
		end else if (out_load && !k_end) begin
			k_q <= k_q + 1'b1;
		end
		if (state_q == pfde_pkg::ST_READ_RD) begin
			rd_inrange_q <= rd_in_range;
		end
		if (out_load) begin
			out_data_q <= rd_inrange_q ? ram_rdata : '0;
			out_last_q <= k_end;
		end
	end

	assign init_done     = init_done_q;
	assign rsp.valid     = out_valid_q;
	assign rsp.data_byte = out_data_q;
	assign rsp.last      = out_last_q;

	a_init_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done_q |-> (state_q == pfde_pkg::ST_FILL))
		else $error("store used before the reset clear finished");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == pfde_pkg::ST_FILL || state_q == pfde_pkg::ST_DRAW_WR))
		else $error("store written outside fill or draw");

	a_draw_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfde_pkg::ST_DRAW_RD) |-> (col_q < op_q.col_hi && page_q <= op_q.page_hi))
		else $error("draw walked past its area");

	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> out_valid_q)
		else $error("pending data beat dropped");

endmodule

FILE: design/page_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
// Page-organised monochrome framebuffer with drawing commands.
// req: one command per beat (clear/fill, pixel, rectangle, glyph column, chunk
//   read). A front end decodes, clips and queues each command that has work; a back end
//   walks the store bytes it touches, with a read-modify-write per byte for draws.
// rsp: a chunk read returns min(CHUNK_BYTES, 32) data beats, last on the final one.
//   Other commands return nothing.
// Operation: a draw reads and then writes each store byte touched (one column in
//   each page row), after the back end takes it from the queue. Clear or fill
//   writes the SCREEN_WIDTH * pages bytes one byte per cycle, after the queue step.
//   A chunk read reads each byte and then loads it into the output register,
//   waiting while rsp stalls.
// Commands are taken while the back end is busy until the queue fills.
// Reset: the store is cleared by a pass over all SCREEN_WIDTH * pages bytes (1024 at
//   the defaults); req.ready stays low until it ends.
// When rsp stalls, the data beat is held in the output register and the back end
//   waits; req keeps accepting until the queue is full.
module page_framebuffer_draw_engine #(
	parameter int SCREEN_WIDTH  = pfde_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = pfde_pkg::DEF_SCREEN_HEIGHT,
	parameter int CHUNK_BYTES   = pfde_pkg::DEF_CHUNK_BYTES,
	parameter int QUEUE_DEPTH   = pfde_pkg::DEF_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	pfde_req_if.sink   req,
	pfde_rsp_if.source rsp
);

	pfde_pkg::op_t       push_op;
	pfde_pkg::op_t       head_op;
	pfde_pkg::q_status_t q_status;
	logic                push;
	logic                pop;
	logic                init_done;

	pfde_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.CHUNK_BYTES   (CHUNK_BYTES)
	) u_front (
		.init_done (init_done),
		.q_status  (q_status),
		.req       (req),
		.push      (push),
		.op        (push_op)
	);

	pfde_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_op),
		.pop    (pop),
		.dout   (head_op),
		.status (q_status)
	);

	pfde_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.CHUNK_BYTES   (CHUNK_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_head    (head_op),
		.q_status  (q_status),
		.pop       (pop),
		.init_done (init_done),
		.rsp       (rsp)
	);

endmodule

FILE: test/page_framebuffer_draw_engine_tb.sv
`timescale 1ns / 1ps
module page_framebuffer_draw_engine_tb;

	localparam int SCR_W       = pfde_pkg::DEF_SCREEN_WIDTH;
	localparam int SCR_H       = pfde_pkg::DEF_SCREEN_HEIGHT;
	localparam int PAGES       = (SCR_H + 7) / 8;
	localparam int STORE_BYTES = SCR_W * PAGES;
	localparam int READ_LEN    = (pfde_pkg::DEF_CHUNK_BYTES < pfde_pkg::MAX_READ)
	                             ? pfde_pkg::DEF_CHUNK_BYTES : pfde_pkg::MAX_READ;
	localparam int TAIL_CYCLES = 200;
	localparam int LIMIT_CYCLES = 5_000_000;
	localparam int LONG_HOLD   = 400;

	// cmd codes with no operation behind them
	localparam logic [pfde_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [pfde_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

	typedef struct {
		logic [pfde_pkg::CMD_W-1:0]   cmd;
		logic [pfde_pkg::COORD_W-1:0] x;
		logic [pfde_pkg::COORD_W-1:0] y;
		logic [pfde_pkg::COFF_W-1:0]  coff;
		logic [pfde_pkg::COORD_W-1:0] w;
		logic [pfde_pkg::COORD_W-1:0] h;
		logic                         lit;
		logic [pfde_pkg::BITS_W-1:0]  top;
		logic [pfde_pkg::BITS_W-1:0]  bot;
		logic                         msb;
		logic [pfde_pkg::CHUNK_W-1:0] chunk;
	} cmd_beat_t;

	typedef struct {
		logic [pfde_pkg::DATA_W-1:0] data;
		logic                        last;
	} byte_beat_t;

	logic clk;
	logic arst_n;

	pfde_req_if req_bus ();
	pfde_rsp_if rsp_bus ();

	page_framebuffer_draw_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// Predicted picture, pending commands, bytes still to come back
	logic [pfde_pkg::DATA_W-1:0] pic_store [0:STORE_BYTES-1];
	cmd_beat_t         cmd_backlog[$];
	byte_beat_t        expected_bytes[$];
	cmd_beat_t         on_bus;
	cmd_beat_t         next_beat;
	byte_beat_t        got_beat;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int fail_count     = 0;
	int cycle_count    = 0;
	logic hold_go      = 1'b0;
	logic hold_on;

	// Clock, and known levels on every input from time zero
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.cmd = '0;
		req_bus.x = '0;
		req_bus.y = '0;
		req_bus.col_offset = '0;
		req_bus.width = '0;
		req_bus.height = '0;
		req_bus.on = 1'b0;
		req_bus.top_bits = '0;
		req_bus.bottom_bits = '0;
		req_bus.msb_first = 1'b0;
		req_bus.chunk = '0;
		rsp_bus.ready = 1'b0;
		forever #5 clk = ~clk;
	end

	// Long receiver hold, counted in cycles here once the sequence asks for it
	initial begin
		hold_on = 1'b0;
		wait (hold_go === 1'b1);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_on <= 1'b0;
	end

	// Light or erase one pixel; off-screen pixels are dropped
	function automatic void draw_dot(int col, int row, logic lit);
		int addr;
		logic [pfde_pkg::DATA_W-1:0] mask;
		if (col >= SCR_W || row >= SCR_H)
			return;
		addr = (row >> 3) * SCR_W + col;
		mask = 8'(1 << (row & 7));
		if (lit)
			pic_store[addr] = pic_store[addr] | mask;
		else
			pic_store[addr] = pic_store[addr] & ~mask;
	endfunction

	// Rectangle: end wraps at 256, then clipped to the screen
	function automatic void draw_box(cmd_beat_t b);
		int xe;
		int ye;
		xe = (int'(b.x) + int'(b.w)) & 8'hFF;
		ye = (int'(b.y) + int'(b.h)) & 8'hFF;
		if (xe > SCR_W)
			xe = SCR_W;
		if (ye > SCR_H)
			ye = SCR_H;
		for (int r = b.y; r < ye; r++)
			for (int c = b.x; c < xe; c++)
				draw_dot(c, r, b.lit);
	endfunction

	// Glyph column: set bits only, column x + offset without wrap
	function automatic void draw_glyph_strip(cmd_beat_t b);
		int col;
		logic [pfde_pkg::BITS_W-1:0] m;
		col = int'(b.x) + int'(b.coff);
		for (int r = 0; r < 8; r++) begin
			m = b.msb ? 8'(8'h80 >> r) : 8'(1 << r);
			if ((b.top & m) != 0)
				draw_dot(col, int'(b.y) + r, 1'b1);
			if ((b.bot & m) != 0)
				draw_dot(col, int'(b.y) + r + 8, 1'b1);
		end
	endfunction

	// Update the predicted picture for one accepted command
	function automatic void apply_command(cmd_beat_t b);
		int addr;
		byte_beat_t e;
		case (b.cmd)
			pfde_pkg::CMD_CLEAR: begin
				for (int i = 0; i < STORE_BYTES; i++)
					pic_store[i] = b.lit ? 8'hFF : 8'h00;
			end
			pfde_pkg::CMD_PIXEL: draw_dot(b.x, b.y, b.lit);
			pfde_pkg::CMD_RECT:  draw_box(b);
			pfde_pkg::CMD_GLYPH: draw_glyph_strip(b);
			pfde_pkg::CMD_READ: begin
				for (int k = 0; k < READ_LEN; k++) begin
					addr = int'(b.chunk) * pfde_pkg::DEF_CHUNK_BYTES + k;
					e.data = (addr < STORE_BYTES) ? pic_store[addr] : 8'h00;
					e.last = (k == READ_LEN - 1);
					expected_bytes.push_back(e);
				end
			end
			default: ;
		endcase
	endfunction

	// Command driver: predicts on each accepted beat, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else begin
			if (req_bus.valid && req_bus.ready)
				apply_command(on_bus);
			if (!req_bus.valid || req_bus.ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_beat = cmd_backlog.pop_front();
					on_bus = next_beat;
					req_bus.valid       <= 1'b1;
					req_bus.cmd         <= next_beat.cmd;
					req_bus.x           <= next_beat.x;
					req_bus.y           <= next_beat.y;
					req_bus.col_offset  <= next_beat.coff;
					req_bus.width       <= next_beat.w;
					req_bus.height      <= next_beat.h;
					req_bus.on          <= next_beat.lit;
					req_bus.top_bits    <= next_beat.top;
					req_bus.bottom_bits <= next_beat.bot;
					req_bus.msb_first   <= next_beat.msb;
					req_bus.chunk       <= next_beat.chunk;
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Data monitor: checks each beat, stalls at random or for the long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected data beat: data_byte %0h last %0b",
						rsp_bus.data_byte, rsp_bus.last);
					fail_count++;
				end else begin
					got_beat = expected_bytes.pop_front();
					if (rsp_bus.data_byte !== got_beat.data) begin
						$error("data_byte: expected %0h, actual %0h",
							got_beat.data, rsp_bus.data_byte);
						fail_count++;
					end
					if (rsp_bus.last !== got_beat.last) begin
						$error("last: expected %0b, actual %0b", got_beat.last, rsp_bus.last);
						fail_count++;
					end
				end
			end
			if (hold_on) begin
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("page_framebuffer_draw_engine: mismatch");
			$finish;
		end
	end

	task automatic queue_beat(logic [pfde_pkg::CMD_W-1:0] cmd, int x, int y, int coff,
			int w, int h, logic lit, int top, int bot, logic msb, int chunk);
		cmd_beat_t b;
		b.cmd = cmd;
		b.x = 8'(x);
		b.y = 8'(y);
		b.coff = 4'(coff);
		b.w = 8'(w);
		b.h = 8'(h);
		b.lit = lit;
		b.top = 8'(top);
		b.bot = 8'(bot);
		b.msb = msb;
		b.chunk = 5'(chunk);
		cmd_backlog.push_back(b);
	endtask

	// Random command, biased toward the screen with some full-range values
	function automatic cmd_beat_t rand_beat();
		cmd_beat_t b;
		int sel;
		sel = $urandom_range(0, 99);
		b.x = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 135)) : 8'($urandom);
		b.y = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 71)) : 8'($urandom);
		b.coff = 4'($urandom);
		b.w = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 40)) : 8'($urandom);
		b.h = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 24)) : 8'($urandom);
		b.lit = ($urandom_range(0, 9) < 7);
		b.top = 8'($urandom);
		b.bot = 8'($urandom);
		b.msb = 1'($urandom);
		b.chunk = 5'($urandom);
		if (sel < 3) begin
			b.cmd = pfde_pkg::CMD_CLEAR;
			b.lit = ($urandom_range(0, 2) == 0);
		end else if (sel < 28)
			b.cmd = pfde_pkg::CMD_PIXEL;
		else if (sel < 48)
			b.cmd = pfde_pkg::CMD_RECT;
		else if (sel < 70)
			b.cmd = pfde_pkg::CMD_GLYPH;
		else if (sel < 95)
			b.cmd = pfde_pkg::CMD_READ;
		else
			b.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		return b;
	endfunction

	// Wait until every command is taken and every byte back, then let it settle
	task automatic wait_drained();
		while (cmd_backlog.size() != 0 || req_bus.valid || expected_bytes.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(int n_items, int idle_pct, int stall_pct);
		@(negedge clk);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n_items; i++)
			cmd_backlog.push_back(rand_beat());
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < STORE_BYTES; i++)
			pic_store[i] = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset contents, corners, off-screen, wrap and clip, glyph, spare codes
		queue_beat(pfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_beat(pfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 31);
		queue_beat(pfde_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		queue_beat(pfde_pkg::CMD_PIXEL, 127, 63, 0, 0, 0, 1, 0, 0, 0, 0);
		queue_beat(pfde_pkg::CMD_PIXEL, 128, 5, 0, 0, 0, 1, 0, 0, 0, 0);
		queue_beat(pfde_pkg::CMD_PIXEL, 5, 64, 0, 0, 0, 1, 0, 0, 0, 0);
		queue_beat(pfde_pkg::CMD_PIXEL, 255, 255, 15, 255, 255, 1, 255, 255, 1, 31);
		queue_beat(pfde_pkg::CMD_PIXEL, 0, 63, 0, 0, 0, 1, 0, 0, 0, 0);
		queue_beat(pfde_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_beat(pfde_pkg::CMD_RECT, 10, 3, 0, 20, 12, 1, 0, 0, 0, 0);
		queue_beat(pfde_pkg::CMD_RECT, 200, 0, 0, 100, 10, 1, 0, 0, 0, 0);
		queue_beat(pfde_pkg::CMD_RECT, 120, 60, 0, 60, 10, 1, 0, 0, 0, 0);
		queue_beat(pfde_pkg::CMD_RECT, 30, 30, 0, 0, 5, 1, 0, 0, 0, 0);
		queue_beat(pfde_pkg::CMD_RECT, 12, 5, 0, 4, 4, 0, 0, 0, 0, 0);
		queue_beat(pfde_pkg::CMD_GLYPH, 40, 0, 0, 0, 0, 1, 8'hA5, 8'h3C, 0, 0);
		queue_beat(pfde_pkg::CMD_GLYPH, 250, 0, 15, 0, 0, 1, 8'hFF, 8'hFF, 0, 0);
		queue_beat(pfde_pkg::CMD_GLYPH, 112, 56, 15, 0, 0, 1, 8'hFF, 8'hFF, 1, 0);
		queue_beat(pfde_pkg::CMD_GLYPH, 60, 20, 7, 0, 0, 0, 8'h81, 8'h7E, 1, 0);
		queue_beat(pfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_beat(pfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5);
		queue_beat(pfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 28);
		queue_beat(pfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 31);
		queue_beat(CMD_SPARE_FIRST, 3, 3, 1, 9, 9, 1, 8'hFF, 8'hFF, 1, 2);
		queue_beat(CMD_SPARE_LAST, 7, 7, 2, 9, 9, 1, 8'hFF, 8'hFF, 0, 3);
		queue_beat(pfde_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		queue_beat(pfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 17);
		queue_beat(pfde_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		wait_drained();

		// Long receiver hold while the sender keeps offering, so the queue backs up
		@(negedge clk);
		hold_go = 1'b1;
		run_phase(110, 0, 0);
		run_phase(110, 79, 0);
		run_phase(110, 0, 79);
		run_phase(110, 30, 30);

		if (fail_count == 0 && expected_bytes.size() == 0) begin
			$display("page_framebuffer_draw_engine: match");
		end else begin
			$display("page_framebuffer_draw_engine: mismatch");
		end
		$finish;
	end

endmodule
